/* rtl/core/mcal_pkg.sv */
`timescale 1ns / 1ps

package mcal_pkg;

    localparam int BYTE_W     = 8;
    localparam int OFF_W      = 21;
    localparam int LEN_W      = 22;
    localparam int LEVEL_W    = 3;
    localparam int NEST_DEPTH = 6;
    localparam int HDR_BYTES  = 8;
    localparam int TDATA_W    = 48;

    localparam int MIN_FILE_BYTES = 16;
    localparam int MIN_BOX_SIZE   = 8;
    localparam int MIN_META_SIZE  = 12;
    localparam int MIN_DATA_SIZE  = 18;
    localparam int META_SKIP      = 4;
    localparam int DATA_SKIP      = 8;

    localparam logic [LEVEL_W-1:0] LVL_MOOV = 3'd0;
    localparam logic [LEVEL_W-1:0] LVL_UDTA = 3'd1;
    localparam logic [LEVEL_W-1:0] LVL_META = 3'd2;
    localparam logic [LEVEL_W-1:0] LVL_ILST = 3'd3;
    localparam logic [LEVEL_W-1:0] LVL_COVR = 3'd4;
    localparam logic [LEVEL_W-1:0] LVL_DATA = 3'd5;

    localparam logic [31:0] TYPE_MOOV = 32'h6D6F6F76;
    localparam logic [31:0] TYPE_UDTA = 32'h75647461;
    localparam logic [31:0] TYPE_META = 32'h6D657461;
    localparam logic [31:0] TYPE_ILST = 32'h696C7374;
    localparam logic [31:0] TYPE_COVR = 32'h636F7672;
    localparam logic [31:0] TYPE_DATA = 32'h64617461;

    localparam logic [BYTE_W-1:0] SIG_JPEG0 = 8'hFF;
    localparam logic [BYTE_W-1:0] SIG_JPEG1 = 8'hD8;
    localparam logic [BYTE_W-1:0] SIG_PNG0  = 8'h89;
    localparam logic [BYTE_W-1:0] SIG_PNG1  = 8'h50;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PREFIX = 3'd2;
    localparam logic [2:0] PH_MAGIC0 = 3'd3;
    localparam logic [2:0] PH_MAGIC1 = 3'd4;
    localparam logic [2:0] PH_FOUND  = 3'd5;
    localparam logic [2:0] PH_FAIL   = 3'd6;

    typedef struct packed {
        logic              take;
        logic              last;
        logic [BYTE_W-1:0] data;
    } walk_req_t;

    typedef struct packed {
        logic             found;
        logic             is_png;
        logic [OFF_W-1:0] image_offset;
        logic [LEN_W-1:0] image_length;
    } mcal_result_t;

    function automatic logic [31:0] wanted_type(input logic [LEVEL_W-1:0] lvl);
        logic [31:0] t;
        case (lvl)
            LVL_MOOV: t = TYPE_MOOV;
            LVL_UDTA: t = TYPE_UDTA;
            LVL_META: t = TYPE_META;
            LVL_ILST: t = TYPE_ILST;
            LVL_COVR: t = TYPE_COVR;
            LVL_DATA: t = TYPE_DATA;
            default:  t = TYPE_DATA;
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/mcal_walker.sv */
`timescale 1ns / 1ps

module mcal_walker #(
    parameter int MAX_READ_BYTES = 2097152
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mcal_pkg::walk_req_t    req,
    output mcal_pkg::mcal_result_t res
);
    import mcal_pkg::*;

    localparam int POS_W  = $clog2(MAX_READ_BYTES + 1);
    localparam int BEND_W = 33;
    localparam logic [POS_W-1:0] READ_LIMIT = POS_W'(MAX_READ_BYTES);

    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [2:0]         cnt_reg, cnt_next;
    logic [3:0]         prefix_reg, prefix_next;
    logic [2:0]         phase_reg, phase_next;
    logic [55:0]        hdr_reg, hdr_next;
    logic [POS_W-1:0]   box_end_reg, box_end_next;
    logic [POS_W-1:0]   moov_end_reg, moov_end_next;
    logic [OFF_W-1:0]   img_start_reg, img_start_next;
    logic [LEN_W-1:0]   img_size_reg, img_size_next;
    logic [BYTE_W-1:0]  magic_reg, magic_next;
    logic [POS_W-1:0]   pend_mem [NEST_DEPTH];

    logic [31:0]        box_size;
    logic [31:0]        box_type;
    logic [BEND_W-1:0]  box_start;
    logic [BEND_W-1:0]  box_end;
    logic [BEND_W-1:0]  pos_plus1;
    logic [POS_W-1:0]   parent_end;
    logic [3:0]         prefix_dec;
    logic               push_en;
    logic [LEVEL_W-1:0] push_idx;
    logic               ok;

    assign box_size   = hdr_reg[55:24];
    assign box_type   = {hdr_reg[23:0], req.data};
    assign box_start  = BEND_W'(pos_reg) - BEND_W'(HDR_BYTES - 1);
    assign box_end    = box_start + BEND_W'(box_size);
    assign pos_plus1  = BEND_W'(pos_reg) + BEND_W'(1);
    assign parent_end = (level_reg == LVL_MOOV) ? READ_LIMIT : pend_mem[level_reg];
    assign prefix_dec = (prefix_reg != 4'd0) ? (prefix_reg - 4'd1) : 4'd0;
    assign push_idx   = level_reg + LEVEL_W'(1);

    always_comb begin
        pos_next       = pos_reg;
        level_next     = level_reg;
        cnt_next       = cnt_reg;
        prefix_next    = prefix_reg;
        phase_next     = phase_reg;
        hdr_next       = hdr_reg;
        box_end_next   = box_end_reg;
        moov_end_next  = moov_end_reg;
        img_start_next = img_start_reg;
        img_size_next  = img_size_reg;
        magic_next     = magic_reg;
        push_en        = 1'b0;

        if (req.take && (pos_reg < READ_LIMIT)) begin
            pos_next = pos_reg + POS_W'(1);
            case (phase_reg)
                PH_HEADER: begin
                    hdr_next = {hdr_reg[47:0], req.data};
                    cnt_next = cnt_reg + 3'd1;
                    if (cnt_reg == 3'(HDR_BYTES - 1)) begin
                        cnt_next = 3'd0;
                        if ((box_size < 32'(MIN_BOX_SIZE)) ||
                            (box_end > BEND_W'(parent_end))) begin
                            phase_next = PH_FAIL;
                        end else if (box_type == wanted_type(level_reg)) begin
                            if (level_reg == LVL_MOOV) begin
                                moov_end_next = box_end[POS_W-1:0];
                            end
                            if (level_reg != LVL_DATA) begin
                                level_next = push_idx;
                                push_en    = 1'b1;
                                if (level_reg == LVL_META) begin
                                    if (box_size < 32'(MIN_META_SIZE)) begin
                                        phase_next = PH_FAIL;
                                    end else begin
                                        prefix_next = 4'(META_SKIP);
                                        phase_next  = PH_PREFIX;
                                    end
                                end else begin
                                    phase_next = PH_HEADER;
                                end
                            end else if (box_size < 32'(MIN_DATA_SIZE)) begin
                                phase_next = PH_FAIL;
                            end else begin
                                img_start_next = OFF_W'(box_start + BEND_W'(MIN_FILE_BYTES));
                                img_size_next  = LEN_W'(box_size - 32'(MIN_FILE_BYTES));
                                prefix_next    = 4'(DATA_SKIP);
                                phase_next     = PH_PREFIX;
                            end
                        end else begin
                            box_end_next = box_end[POS_W-1:0];
                            phase_next   = (box_end == pos_plus1) ? PH_HEADER : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    if (pos_plus1 >= BEND_W'(box_end_reg)) begin
                        phase_next = PH_HEADER;
                    end
                end
                PH_PREFIX: begin
                    prefix_next = prefix_dec;
                    if (prefix_dec == 4'd0) begin
                        phase_next = (level_reg == LVL_DATA) ? PH_MAGIC0 : PH_HEADER;
                    end
                end
                PH_MAGIC0: begin
                    magic_next = req.data;
                    phase_next = PH_MAGIC1;
                end
                PH_MAGIC1: begin
                    if (((magic_reg == SIG_JPEG0) && (req.data == SIG_JPEG1)) ||
                        ((magic_reg == SIG_PNG0) && (req.data == SIG_PNG1))) begin
                        phase_next = PH_FOUND;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                default: begin
                end
            endcase
        end

        ok = (phase_next == PH_FOUND) && (moov_end_next <= pos_next) &&
             (pos_next >= POS_W'(MIN_FILE_BYTES));
        res.found        = ok;
        res.is_png       = ok && (magic_next == SIG_PNG0);
        res.image_offset = ok ? img_start_next : '0;
        res.image_length = ok ? img_size_next : '0;

        // file done, start over for the next one
        if (req.take && req.last) begin
            pos_next    = '0;
            level_next  = LVL_MOOV;
            cnt_next    = 3'd0;
            prefix_next = 4'd0;
            phase_next  = PH_HEADER;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= '0;
            level_reg  <= LVL_MOOV;
            cnt_reg    <= 3'd0;
            prefix_reg <= 4'd0;
            phase_reg  <= PH_HEADER;
        end else begin
            pos_reg    <= pos_next;
            level_reg  <= level_next;
            cnt_reg    <= cnt_next;
            prefix_reg <= prefix_next;
            phase_reg  <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        hdr_reg       <= hdr_next;
        box_end_reg   <= box_end_next;
        moov_end_reg  <= moov_end_next;
        img_start_reg <= img_start_next;
        img_size_reg  <= img_size_next;
        magic_reg     <= magic_next;
        if (push_en) begin
            pend_mem[push_idx] <= box_end[POS_W-1:0];
        end
    end

    a_level_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        level_reg <= LVL_DATA)
        else $error("nest level beyond data box");

    a_found_at_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_FOUND) |-> (level_reg == LVL_DATA))
        else $error("image found outside data box");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.take && req.last) |=> ((pos_reg == '0) && (phase_reg == PH_HEADER)))
        else $error("walker did not restart after last byte");

endmodule

/* rtl/core/mp4_cover_art_locator_unit.sv */
`timescale 1ns / 1ps

// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tdata file byte, s_tlast end of file
// m_       out  m_tvalid/m_tready  m_tdata found/offset/length, m_tuser png
//
// one byte per cycle unless a last byte waits for a busy result slot; input register, then result register
// per-byte work is a header compare plus one 33-bit box end add and compare
// aresetn synchronous, clears the walker and both handshake stages
// a stalled result only holds back the last byte of the next file
// parser state returns to reset after each last byte

module mp4_cover_art_locator_unit #(
    parameter int MAX_READ_BYTES = 2097152
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [mcal_pkg::BYTE_W-1:0]      s_tdata,  // [7:0] file_byte
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [mcal_pkg::TDATA_W-1:0]     m_tdata,  // [0] found, [21:1] image_offset,
                                                       // [43:22] image_length, rest zero
    output logic                             m_tuser   // [0] is_png
);
    import mcal_pkg::*;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_last_reg;
    logic              out_valid_reg;
    mcal_result_t      res_reg;
    mcal_result_t      walk_res;
    walk_req_t         walk_req;
    logic              out_free;
    logic              proc;

    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && (!in_last_reg || out_free);
    assign s_tready = !in_valid_reg || proc;

    assign walk_req.take = proc;
    assign walk_req.last = in_last_reg;
    assign walk_req.data = in_data_reg;

    mcal_walker #(
        .MAX_READ_BYTES(MAX_READ_BYTES)
    ) u_walker (
        .aclk   (aclk),
        .aresetn(aresetn),
        .req    (walk_req),
        .res    (walk_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (proc && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (proc && in_last_reg) begin
            res_reg <= walk_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(TDATA_W - 1 - OFF_W - LEN_W)'(0), res_reg.image_length,
                       res_reg.image_offset, res_reg.found};
    assign m_tuser  = res_reg.is_png;

    a_last_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && in_last_reg && out_valid_reg && !m_tready) |-> !s_tready)
        else $error("last byte taken while result slot busy");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(proc && in_last_reg))
        else $error("result without a last byte");

    a_found_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && res_reg.found) |-> (res_reg.image_length >= LEN_W'(2)))
        else $error("found image shorter than signature");

endmodule
